/* design/dit_pkg.sv */
`default_nettype none

package dit_pkg;

    // Fixed widths of the block's fields and state
    localparam int NOW_W  = 32;
    localparam int QUIET_W = 16;
    localparam int MODE_W = 2;
    localparam int FUNC_W = 2;
    localparam int CNT_W  = 4;
    localparam int IDX_W  = 2;
    localparam int DATA_W = 16;
    localparam int STEP_W = 4;

    localparam logic [CNT_W-1:0] MAX_CYCLES = CNT_W'(15);

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CHANGE = 2'd0,
        FUNC_POLL   = 2'd1,
        FUNC_START  = 2'd2
    } func_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE   = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_ALL    = 2'd2
    } mode_t;

    localparam logic [IDX_W-1:0] CFG_QUIET = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MODE  = 2'd1;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LATCH,
        OP_COMMIT,
        OP_EMIT_INV,
        OP_EMIT_PREV,
        OP_EMIT_FINAL,
        OP_PIN_CHANGE,
        OP_START
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_IDLE,
        COND_FUNC_CHG,
        COND_FUNC_START,
        COND_NOT_POLL,
        COND_CNT_ZERO,
        COND_NO_FINAL
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  stall;   // wait here while the result register is full and not taken
        logic  in_rdy;  // step takes an input beat
        step_t target;
    } uword_t;

    // Controller to datapath
    typedef struct packed {
        op_t  op;
        logic fire;
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              cnt_zero;
        logic              final_flag;
        logic              out_free;
    } stat_t;

    localparam step_t S_FETCH    = 4'd0;
    localparam step_t S_DISP_CHG = 4'd1;
    localparam step_t S_DISP_ST  = 4'd2;
    localparam step_t S_DISP_PL  = 4'd3;
    localparam step_t S_COMMIT   = 4'd4;
    localparam step_t S_LOOP     = 4'd5;
    localparam step_t S_EMIT_INV = 4'd6;
    localparam step_t S_EMIT_PRV = 4'd7;
    localparam step_t S_TAIL     = 4'd8;
    localparam step_t S_EMIT_FIN = 4'd9;
    localparam step_t S_CHANGE   = 4'd10;
    localparam step_t S_START    = 4'd11;

    function automatic uword_t ucode_rom(step_t s);
        uword_t w;
        unique case (s)
            S_FETCH:    w = '{OP_LATCH,      COND_IN_IDLE,    1'b0, 1'b1, S_FETCH};
            S_DISP_CHG: w = '{OP_NOP,        COND_FUNC_CHG,   1'b0, 1'b0, S_CHANGE};
            S_DISP_ST:  w = '{OP_NOP,        COND_FUNC_START, 1'b0, 1'b0, S_START};
            S_DISP_PL:  w = '{OP_NOP,        COND_NOT_POLL,   1'b0, 1'b0, S_FETCH};
            S_COMMIT:   w = '{OP_COMMIT,     COND_ALWAYS,     1'b0, 1'b0, S_LOOP};
            S_LOOP:     w = '{OP_NOP,        COND_CNT_ZERO,   1'b0, 1'b0, S_TAIL};
            S_EMIT_INV: w = '{OP_EMIT_INV,   COND_ALWAYS,     1'b1, 1'b0, S_EMIT_PRV};
            S_EMIT_PRV: w = '{OP_EMIT_PREV,  COND_ALWAYS,     1'b1, 1'b0, S_LOOP};
            S_TAIL:     w = '{OP_NOP,        COND_NO_FINAL,   1'b0, 1'b0, S_FETCH};
            S_EMIT_FIN: w = '{OP_EMIT_FINAL, COND_ALWAYS,     1'b1, 1'b0, S_FETCH};
            S_CHANGE:   w = '{OP_PIN_CHANGE, COND_ALWAYS,     1'b0, 1'b0, S_FETCH};
            S_START:    w = '{OP_START,      COND_ALWAYS,     1'b0, 1'b0, S_FETCH};
            default:    w = '{OP_NOP,        COND_ALWAYS,     1'b0, 1'b0, S_FETCH};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* design/dit_ifs.sv */
`default_nettype none

interface dit_in_if;
    logic                      valid;
    logic                      ready;
    logic [dit_pkg::FUNC_W-1:0] func;
    logic                      pin_level;
    logic [dit_pkg::NOW_W-1:0]  now_ms;

    modport source (output valid, output func, output pin_level, output now_ms, input ready);
    modport sink   (input valid, input func, input pin_level, input now_ms, output ready);
endinterface

interface dit_out_if;
    logic valid;
    logic ready;
    logic level_value;
    logic last_of_run;

    modport source (output valid, output level_value, output last_of_run, input ready);
    modport sink   (input valid, input level_value, input last_of_run, output ready);
endinterface

interface dit_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [dit_pkg::IDX_W-1:0]  index;
    logic [dit_pkg::DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/debounced_input_toggle_counter.sv */
// Debounced input toggle counter.
// Channels: in_ch takes events (func: pin change, poll, start) with the pin
// level and a millisecond stamp; out_ch delivers reported levels, one beat
// per level, with last_of_run on the final beat of a poll; cfg writes
// quiet_interval (index 0) and cycle_mode (index 1) and is always ready.
// A small microprogram steps the datapath one control word per cycle,
// except while an emit step is stalled. A poll reports at most 15 toggle
// cycles, and the new level may be reported after the toggles.
// One item is worked on at a time; in_ch.ready is high only in the fetch
// step, while an earlier final result may still wait in the output register.
// When the result register is full and out_ch.ready is low, the sequencer
// holds on its emit step and the result register keeps its beat. Reset sets
// level 0, no pending cycles, quiet_interval 50 and cycle_mode 2; the
// latched beat and poll working registers are not reset.
`default_nettype none

module debounced_input_toggle_counter (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dit_in_if.sink     in_ch,
    dit_out_if.source  out_ch,
    dit_cfg_if.sink    cfg
);
    import dit_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    dit_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    dit_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .func        (in_ch.func),
        .pin_level   (in_ch.pin_level),
        .now_ms      (in_ch.now_ms),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .level_value (out_ch.level_value),
        .last_of_run (out_ch.last_of_run),
        .cfg_valid   (cfg.valid),
        .cfg_ready   (cfg.ready),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data)
    );

endmodule

`default_nettype wire

/* design/dit_seq.sv */
`default_nettype none

module dit_seq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire dit_pkg::stat_t stat,
    output dit_pkg::ctl_t      ctl
);
    import dit_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    uword_t word;
    logic   in_fire;
    logic   blocked;
    logic   cond_true;

    assign word    = ucode_rom(step_reg);
    assign in_fire = word.in_rdy & in_valid;
    assign blocked = word.stall & ~stat.out_free;

    always_comb
    begin
        unique case (word.cond)
            COND_ALWAYS:     cond_true = 1'b1;
            COND_IN_IDLE:    cond_true = ~in_fire;
            COND_FUNC_CHG:   cond_true = (stat.func == FUNC_CHANGE);
            COND_FUNC_START: cond_true = (stat.func == FUNC_START);
            COND_NOT_POLL:   cond_true = (stat.func != FUNC_POLL);
            COND_CNT_ZERO:   cond_true = stat.cnt_zero;
            COND_NO_FINAL:   cond_true = ~stat.final_flag;
            default:         cond_true = 1'b1;
        endcase

        priority if (blocked)
            step_next = step_reg;
        else if (cond_true)
            step_next = word.target;
        else
            step_next = step_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= S_FETCH;
        else
            step_reg <= step_next;
    end

    assign in_ready = word.in_rdy;
    assign ctl.op   = word.op;
    assign ctl.fire = word.in_rdy ? in_fire : ~blocked;

endmodule

`default_nettype wire

/* design/dit_dp.sv */
`default_nettype none

module dit_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire dit_pkg::ctl_t               ctl,
    output dit_pkg::stat_t                   stat,
    input  wire logic [dit_pkg::FUNC_W-1:0]  func,
    input  wire logic                        pin_level,
    input  wire logic [dit_pkg::NOW_W-1:0]   now_ms,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic                             level_value,
    output logic                             last_of_run,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [dit_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [dit_pkg::DATA_W-1:0]  cfg_data
);
    import dit_pkg::*;

    // latched input beat
    logic [FUNC_W-1:0]  func_reg;
    logic               pin_reg;
    logic [NOW_W-1:0]   now_reg;

    // tracked state
    logic               raw_reg,      raw_next;
    logic               settled_reg,  settled_next;
    logic [NOW_W-1:0]   ltime_reg,    ltime_next;
    logic [CNT_W-1:0]   pend_reg,     pend_next;
    logic               first_reg,    first_next;
    logic [QUIET_W-1:0] quiet_reg,    quiet_next;
    logic [MODE_W-1:0]  mode_reg,     mode_next;

    // poll working registers
    logic [CNT_W-1:0]   cnt_reg,      cnt_next;
    logic               prev_reg,     prev_next;
    logic               final_reg,    final_next;

    // result register
    logic               oval_reg,     oval_next;
    logic               olev_reg,     olev_next;
    logic               olast_reg,    olast_next;

    logic [NOW_W-1:0]   elapsed;
    logic               quiet_ok;
    logic               new_settled;
    logic [CNT_W-1:0]   cnt_sel;
    logic               out_free;
    logic               latch_en;

    assign elapsed     = now_reg - ltime_reg;
    assign quiet_ok    = elapsed > {{(NOW_W-QUIET_W){1'b0}}, quiet_reg};
    assign new_settled = quiet_ok ? raw_reg : settled_reg;
    assign out_free    = ~oval_reg | out_ready;
    assign latch_en    = (ctl.op == OP_LATCH) & ctl.fire;

    always_comb
    begin
        unique case (mode_reg)
            MODE_NONE:   cnt_sel = '0;
            MODE_SINGLE: cnt_sel = (pend_reg != '0 && new_settled == settled_reg)
                                   ? CNT_W'(1) : '0;
            default:     cnt_sel = pend_reg;
        endcase
    end

    always_comb
    begin
        raw_next     = raw_reg;
        settled_next = settled_reg;
        ltime_next   = ltime_reg;
        pend_next    = pend_reg;
        first_next   = first_reg;
        quiet_next   = quiet_reg;
        mode_next    = mode_reg;
        cnt_next     = cnt_reg;
        prev_next    = prev_reg;
        final_next   = final_reg;
        olev_next    = olev_reg;
        olast_next   = olast_reg;
        oval_next    = oval_reg & ~out_ready;

        if (cfg_valid)
        begin
            // drop writes to unused indexes
            unique case (cfg_index)
                CFG_QUIET: quiet_next = cfg_data[QUIET_W-1:0];
                CFG_MODE:  mode_next  = cfg_data[MODE_W-1:0];
                default:
                begin
                end
            endcase
        end

        if (ctl.fire)
        begin
            unique case (ctl.op)
                OP_PIN_CHANGE:
                begin
                    if (pin_reg != raw_reg)
                    begin
                        raw_next   = pin_reg;
                        ltime_next = now_reg;
                        if (quiet_ok && pin_reg == settled_reg && pend_reg < MAX_CYCLES)
                            pend_next = pend_reg + CNT_W'(1);
                    end
                end
                OP_START:
                begin
                    raw_next     = pin_reg;
                    settled_next = pin_reg;
                    ltime_next   = now_reg;
                    first_next   = 1'b1;
                end
                OP_COMMIT:
                begin
                    prev_next    = settled_reg;
                    settled_next = new_settled;
                    cnt_next     = cnt_sel;
                    final_next   = (first_reg && cnt_sel == '0) ||
                                   (new_settled != settled_reg);
                    pend_next    = '0;
                    first_next   = 1'b0;
                end
                OP_EMIT_INV:
                begin
                    oval_next  = 1'b1;
                    olev_next  = ~prev_reg;
                    olast_next = 1'b0;
                end
                OP_EMIT_PREV:
                begin
                    oval_next  = 1'b1;
                    olev_next  = prev_reg;
                    olast_next = (cnt_reg == CNT_W'(1)) & ~final_reg;
                    cnt_next   = cnt_reg - CNT_W'(1);
                end
                OP_EMIT_FINAL:
                begin
                    oval_next  = 1'b1;
                    olev_next  = settled_reg;
                    olast_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (latch_en)
        begin
            func_reg <= func;
            pin_reg  <= pin_level;
            now_reg  <= now_ms;
        end
        cnt_reg   <= cnt_next;
        prev_reg  <= prev_next;
        final_reg <= final_next;
        olev_reg  <= olev_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg     <= 1'b0;
            settled_reg <= 1'b0;
            ltime_reg   <= '0;
            pend_reg    <= '0;
            first_reg   <= 1'b0;
            quiet_reg   <= QUIET_W'(50);
            mode_reg    <= MODE_ALL;
            oval_reg    <= 1'b0;
        end
        else
        begin
            raw_reg     <= raw_next;
            settled_reg <= settled_next;
            ltime_reg   <= ltime_next;
            pend_reg    <= pend_next;
            first_reg   <= first_next;
            quiet_reg   <= quiet_next;
            mode_reg    <= mode_next;
            oval_reg    <= oval_next;
        end
    end

    assign stat.func       = func_reg;
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.final_flag = final_reg;
    assign stat.out_free   = out_free;

    assign out_valid   = oval_reg;
    assign level_value = olev_reg;
    assign last_of_run = olast_reg;
    assign cfg_ready   = 1'b1;

endmodule

`default_nettype wire

/* design/dit_checker.sv */
`default_nettype none

module dit_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_level,
    input wire logic out_last,
    input wire logic cfg_valid,
    input wire logic cfg_ready
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_last))
        else $error("result beat changed while stalled");

    // only a run's final beat may still wait when the next event is taken
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> out_last)
        else $error("input ready while a poll run is unfinished");

    // one event at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an accepted beat");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind debounced_input_toggle_counter dit_checker u_dit_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_level (out_ch.level_value),
    .out_last  (out_ch.last_of_run),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);

`default_nettype wire
